// ===== src/tspg_pkg.sv =====
// Shared constants, types and command/status bundles for the step-pulse generator.
package tspg_pkg;

	localparam int STEP_BITS = 24;

	localparam int ELAPSED_W  = 16;
	localparam int COUNT_W    = 24;
	localparam int EVENT_W    = 2;
	localparam int IVL_W      = 24;
	localparam int TACC_W     = 32;
	localparam int MINI_W     = 16;
	localparam int ACCEL_W    = 20;
	localparam int RAMP_W     = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 56;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCELERATION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEPS   = 2'd2;

	localparam logic [MINI_W-1:0]  MINI_RESET  = 16'd100;
	localparam logic [ACCEL_W-1:0] ACCEL_RESET = 20'd20000;
	localparam logic [RAMP_W-1:0]  RAMP_RESET  = 24'd2500;

	localparam logic [IVL_W-1:0]  IVL_MAX  = {IVL_W{1'b1}};
	localparam logic [TACC_W-1:0] TACC_MAX = {TACC_W{1'b1}};

	// ramp split compare width
	localparam int SPL_W = ((STEP_BITS > RAMP_W) ? STEP_BITS : RAMP_W) + 1;

	// ramp step number, 2*accel*n product, radicand scaled by 2^16
	localparam int N_W        = STEP_BITS + 1;
	localparam int PROD_W     = ACCEL_W + N_W + 1;
	localparam int RAD_W      = PROD_W + 16;
	localparam int ROOT_CYC   = (RAD_W + 3) / 4;
	localparam int RAD_PAD_W  = 4 * ROOT_CYC;
	localparam int ROOT_W     = 2 * ROOT_CYC;
	localparam int REM_W      = ROOT_W + 2;

	// 1e6 scaled by 2^8, divided two quotient bits per cycle
	localparam int QUO_W   = 28;
	localparam int DIV_CYC = QUO_W / 2;
	localparam logic [QUO_W-1:0] SCALED_MICRO = 28'd256000000;

	localparam int CNT_W = $clog2((ROOT_CYC > DIV_CYC) ? ROOT_CYC : DIV_CYC);

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE = 2'd0,
		EV_ON   = 2'd1,
		EV_OFF  = 2'd2
	} event_t;

	typedef struct packed {
		logic accept;
		logic edge_chk;
		logic mul;
		logic root_step;
		logic div_step;
		logic ivl_write;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic load_req;
		logic cruise;
	} sts_t;

endpackage

// ===== src/trapezoid_step_pulse_generator.sv =====
// A request is taken in idle and checked for a step edge. When an interval load is due,
// the cruise interval is written, or a ramp interval is computed by square root and
// divide and then written. The result is then registered once the output is free.
// One request at a time; the next is taken the cycle after the result is registered.
// The result register lets a new request in while the previous result waits.
// Reset: arst_n clears move state and output valid; config registers get their defaults.
module trapezoid_step_pulse_generator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [tspg_pkg::IN_DATA_W-1:0]      s_tdata,   // elapsed_us[15:0], step_count[39:16]
	input  logic                                s_tuser,   // func
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tspg_pkg::OUT_DATA_W-1:0]     m_tdata,   // steps_done[23:0], busy_res[24],
	                                                       // interval_us[48:25], zero[55:49]
	output logic [tspg_pkg::EVENT_W-1:0]        m_tuser,   // step_event
	input  logic                                cfg_we,
	input  logic [tspg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tspg_pkg::CFG_DATA_W-1:0]     cfg_data
);

	tspg_pkg::cmd_t                  cmd;
	tspg_pkg::sts_t                  sts;
	logic [tspg_pkg::COUNT_W-1:0]    steps_done;
	logic                            busy_res;
	logic [tspg_pkg::IVL_W-1:0]      interval_us;

	tspg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tspg_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_func         (s_tuser),
		.in_elapsed_us   (s_tdata[15:0]),
		.in_step_count   (s_tdata[39:16]),
		.out_step_event  (m_tuser),
		.out_steps_done  (steps_done),
		.out_busy_res    (busy_res),
		.out_interval_us (interval_us)
	);

	assign m_tdata = {7'b0, interval_us, busy_res, steps_done};

endmodule

// ===== src/tspg_ctrl.sv =====
// Sequencer for the step-pulse generator: handshakes and the interval computation steps.
module tspg_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  tspg_pkg::sts_t  sts,
	output tspg_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE,
		ST_MUL,
		ST_ROOT,
		ST_DIV,
		ST_WRITE,
		ST_FIN
	} state_t;

	state_t                        state_q;
	logic [tspg_pkg::CNT_W-1:0]    cnt_q;
	logic                          m_tvalid_q;
	logic                          out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		cmd           = '0;
		cmd.accept    = (state_q == ST_IDLE) && s_tvalid;
		cmd.edge_chk  = (state_q == ST_EDGE);
		cmd.mul       = (state_q == ST_MUL);
		cmd.root_step = (state_q == ST_ROOT);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.ivl_write = (state_q == ST_WRITE);
		cmd.out_load  = (state_q == ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid)
						state_q <= ST_EDGE;
				end
				ST_EDGE: begin
					state_q <= sts.load_req ? ST_MUL : ST_FIN;
				end
				ST_MUL: begin
					cnt_q   <= '0;
					state_q <= sts.cruise ? ST_WRITE : ST_ROOT;
				end
				ST_ROOT: begin
					if (cnt_q == tspg_pkg::CNT_W'(tspg_pkg::ROOT_CYC - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (cnt_q == tspg_pkg::CNT_W'(tspg_pkg::DIV_CYC - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_WRITE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_WRITE: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/tspg_dp.sv =====
// Datapath: move state, time accumulator, ramp root and divide, result register.
module tspg_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tspg_pkg::cmd_t                       cmd,
	output tspg_pkg::sts_t                       sts,
	input  logic                                 cfg_we,
	input  logic [tspg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tspg_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_func,
	input  logic [tspg_pkg::ELAPSED_W-1:0]       in_elapsed_us,
	input  logic [tspg_pkg::COUNT_W-1:0]         in_step_count,
	output logic [tspg_pkg::EVENT_W-1:0]         out_step_event,
	output logic [tspg_pkg::COUNT_W-1:0]         out_steps_done,
	output logic                                 out_busy_res,
	output logic [tspg_pkg::IVL_W-1:0]           out_interval_us
);

	// configuration
	logic [tspg_pkg::MINI_W-1:0]  mini_q;
	logic [tspg_pkg::ACCEL_W-1:0] accel_q;
	logic [tspg_pkg::RAMP_W-1:0]  ramp_q;

	// move state
	logic [tspg_pkg::TACC_W-1:0]     tacc_q;
	logic [tspg_pkg::IVL_W-1:0]      ivl_q;
	logic [tspg_pkg::STEP_BITS-1:0]  done_q;
	logic [tspg_pkg::STEP_BITS-1:0]  len_q;
	logic [tspg_pkg::STEP_BITS-1:0]  cruise_q;
	logic [tspg_pkg::STEP_BITS-1:0]  decel_q;
	logic                            phase_q;
	logic                            func_q;
	tspg_pkg::event_t                event_q;

	// interval unit
	logic                             cru_q;
	logic [tspg_pkg::RAD_PAD_W-1:0]   rad_q;
	logic [tspg_pkg::REM_W-1:0]       rrem_q;
	logic [tspg_pkg::ROOT_W-1:0]      root_q;
	logic [tspg_pkg::ROOT_W:0]        drem_q;
	logic [tspg_pkg::QUO_W-1:0]       dquo_q;

	// result register
	tspg_pkg::event_t                 out_event_q;
	logic [tspg_pkg::COUNT_W-1:0]     out_done_q;
	logic                             out_busy_q;
	logic [tspg_pkg::IVL_W-1:0]       out_ivl_q;

	logic                             busy;
	logic [tspg_pkg::STEP_BITS-1:0]   len_new;
	logic [tspg_pkg::SPL_W-1:0]       len_w;
	logic                             short_move;
	logic [tspg_pkg::STEP_BITS-1:0]   half_len;
	logic [tspg_pkg::STEP_BITS-1:0]   decel_long;
	logic [tspg_pkg::TACC_W:0]        sum_w;
	logic [tspg_pkg::TACC_W-1:0]      sum_sat;
	logic [tspg_pkg::TACC_W-1:0]      ivl_w;
	logic                             fire;
	logic                             mid;
	logic [tspg_pkg::N_W-1:0]         n_val;
	logic [tspg_pkg::PROD_W-1:0]      prod;
	logic [tspg_pkg::REM_W-1:0]       r_nx;
	logic [tspg_pkg::ROOT_W-1:0]      q_nx;
	logic [tspg_pkg::RAD_PAD_W-1:0]   x_nx;
	logic [tspg_pkg::REM_W-1:0]       trial;
	logic [tspg_pkg::ROOT_W:0]        dr_nx;
	logic [tspg_pkg::QUO_W-1:0]       dq_nx;
	logic [tspg_pkg::ROOT_W:0]        divisor;
	logic [tspg_pkg::IVL_W-1:0]       ramp_ivl;

	assign busy = (done_q != len_q);

	// ramp split for a new move
	assign len_new    = tspg_pkg::STEP_BITS'(in_step_count);
	assign len_w      = tspg_pkg::SPL_W'(len_new);
	assign short_move = len_w < tspg_pkg::SPL_W'({ramp_q, 1'b0});
	assign half_len   = len_new >> 1;
	assign decel_long = tspg_pkg::STEP_BITS'(len_w - tspg_pkg::SPL_W'(ramp_q));

	assign sum_w   = (tspg_pkg::TACC_W + 1)'(tacc_q) + (tspg_pkg::TACC_W + 1)'(in_elapsed_us);
	assign sum_sat = sum_w[tspg_pkg::TACC_W] ? tspg_pkg::TACC_MAX
	                                         : sum_w[tspg_pkg::TACC_W-1:0];

	assign ivl_w = tspg_pkg::TACC_W'(ivl_q);
	assign fire  = !func_q && busy && (tacc_q > ivl_w);

	// n counts from the near end of the ramp
	assign mid   = (done_q > cruise_q) && (done_q < decel_q);
	assign n_val = (done_q <= cruise_q) ? tspg_pkg::N_W'(done_q) + 1'b1
	                                    : tspg_pkg::N_W'(tspg_pkg::STEP_BITS'(len_q - done_q));
	assign prod  = tspg_pkg::PROD_W'({accel_q, 1'b0}) * tspg_pkg::PROD_W'(n_val);

	assign sts.load_req = func_q || (fire && !phase_q);
	assign sts.cruise   = mid;

	// two radicand bit pairs of the square root per cycle
	always_comb begin
		r_nx  = rrem_q;
		q_nx  = root_q;
		x_nx  = rad_q;
		trial = '0;
		for (int k = 0; k < 2; k++) begin
			r_nx  = {r_nx[tspg_pkg::REM_W-3:0], x_nx[tspg_pkg::RAD_PAD_W-1 -: 2]};
			x_nx  = x_nx << 2;
			q_nx  = q_nx << 1;
			trial = tspg_pkg::REM_W'({q_nx, 1'b1});
			if (r_nx >= trial) begin
				r_nx    = r_nx - trial;
				q_nx[0] = 1'b1;
			end
		end
	end

	// two quotient bits per cycle, dividend shifts out as quotient shifts in
	assign divisor = (tspg_pkg::ROOT_W + 1)'(root_q);
	always_comb begin
		dr_nx = drem_q;
		dq_nx = dquo_q;
		for (int k = 0; k < 2; k++) begin
			dr_nx = {dr_nx[tspg_pkg::ROOT_W-1:0], dq_nx[tspg_pkg::QUO_W-1]};
			dq_nx = dq_nx << 1;
			if (dr_nx >= divisor) begin
				dr_nx    = dr_nx - divisor;
				dq_nx[0] = 1'b1;
			end
		end
	end

	assign ramp_ivl = ((root_q == '0) || (dquo_q > tspg_pkg::QUO_W'(tspg_pkg::IVL_MAX)))
	                  ? tspg_pkg::IVL_MAX : tspg_pkg::IVL_W'(dquo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mini_q   <= tspg_pkg::MINI_RESET;
			accel_q  <= tspg_pkg::ACCEL_RESET;
			ramp_q   <= tspg_pkg::RAMP_RESET;
			tacc_q   <= '0;
			ivl_q    <= '0;
			done_q   <= '0;
			len_q    <= '0;
			cruise_q <= '0;
			decel_q  <= '0;
			phase_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tspg_pkg::CFG_MIN_INTERVAL: mini_q  <= tspg_pkg::MINI_W'(cfg_data);
					tspg_pkg::CFG_ACCELERATION: accel_q <= tspg_pkg::ACCEL_W'(cfg_data);
					tspg_pkg::CFG_RAMP_STEPS:   ramp_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.accept) begin
				if (in_func) begin
					len_q  <= len_new;
					done_q <= '0;
					tacc_q <= '0;
					if (short_move) begin
						cruise_q <= half_len;
						decel_q  <= half_len;
					end else begin
						cruise_q <= tspg_pkg::STEP_BITS'(ramp_q);
						decel_q  <= decel_long;
					end
				end else if (busy) begin
					tacc_q <= sum_sat;
				end
			end
			if (cmd.edge_chk && fire) begin
				tacc_q  <= tacc_q - ivl_w;
				phase_q <= !phase_q;
				if (phase_q)
					done_q <= done_q + 1'b1;
			end
			if (cmd.ivl_write)
				ivl_q <= cru_q ? tspg_pkg::IVL_W'(mini_q) : ramp_ivl;
		end
	end

	// item, interval unit and result registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q  <= in_func;
			event_q <= tspg_pkg::EV_NONE;
		end
		if (cmd.edge_chk && fire)
			event_q <= phase_q ? tspg_pkg::EV_ON : tspg_pkg::EV_OFF;
		if (cmd.mul) begin
			cru_q  <= mid;
			rad_q  <= tspg_pkg::RAD_PAD_W'({prod, 16'h0000});
			rrem_q <= '0;
			root_q <= '0;
			drem_q <= '0;
			dquo_q <= tspg_pkg::SCALED_MICRO;
		end
		if (cmd.root_step) begin
			rad_q  <= rad_q << 4;
			rrem_q <= r_nx;
			root_q <= q_nx;
		end
		if (cmd.div_step) begin
			drem_q <= dr_nx;
			dquo_q <= dq_nx;
		end
		if (cmd.out_load) begin
			out_event_q <= event_q;
			out_done_q  <= tspg_pkg::COUNT_W'(done_q);
			out_busy_q  <= busy;
			out_ivl_q   <= ivl_q;
		end
	end

	assign out_step_event  = out_event_q;
	assign out_steps_done  = out_done_q;
	assign out_busy_res    = out_busy_q;
	assign out_interval_us = out_ivl_q;

endmodule
